// ===== hw/rtl/stack_bytecode_executor_top_macros.svh =====
// Assertion macros shared by the stack bytecode executor modules
`ifndef STACK_BYTECODE_EXECUTOR_TOP_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_TOP_MACROS_SVH
`ifndef SYNTH
`define SBE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SBE_ASSERT_SAME(lbl, ante, cons, msg)
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sbe_pkg.sv =====
// Types, opcodes and controller/datapath structs for the stack bytecode executor
`timescale 1ns / 1ps
package sbe_pkg;

	typedef logic [7:0]         byte_t;
	typedef logic [31:0]        word_t;
	typedef logic signed [31:0] value_t;
	typedef logic [1:0]         status_t;

	localparam byte_t OP_ADD   = 8'd0;
	localparam byte_t OP_SUB   = 8'd1;
	localparam byte_t OP_MUL   = 8'd2;
	localparam byte_t OP_DIV   = 8'd3;
	localparam byte_t OP_MOD   = 8'd4;
	localparam byte_t OP_PUSH  = 8'd5;
	localparam byte_t OP_PRINT = 8'd6;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_UNDER   = 2'd1;
	localparam status_t ST_OVER    = 2'd2;
	localparam status_t ST_DIVZERO = 2'd3;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic    byte_ld;
		logic    imm_set;
		logic    imm_clr;
		logic    push_imm;
		logic    rd_en;
		logic    rd_second;
		logic    ld_right;
		logic    ld_left;
		logic    res_from_rd;
		logic    pop;
		logic    alu_exec;
		logic    div_init;
		logic    div_step;
		logic    div_fin;
		logic    wb;
		logic    emit_ld;
		logic    emit_zero;
		status_t emit_status;
	} sbe_cmd_t;

	typedef struct packed {
		byte_t code;
		logic  expect_imm;
		logic  cnt_zero;
		logic  cnt_lt2;
		logic  cnt_full;
		logic  right_zero;
		logic  out_free;
	} sbe_sts_t;

endpackage

// ===== hw/rtl/sbe_stream_if.sv =====
// Valid/ready channel interfaces for bytecode input and print results
`timescale 1ns / 1ps
interface sbe_code_if import sbe_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface sbe_result_if import sbe_pkg::*; ();
	logic    valid;
	logic    ready;
	value_t  printed_value;
	status_t status;

	modport source (output valid, output printed_value, output status, input ready);
	modport sink (input valid, input printed_value, input status, output ready);
endinterface

// ===== hw/rtl/stack_bytecode_executor_top.sv =====
// Stack bytecode executor top level: controller plus stack datapath.
// Push, unknown bytes and a stored immediate that fits go through decode to idle.
// Print reads and pops the top, then emits; add/sub/mul read both operands,
// execute and write back; div/mod first run the one-bit-per-cycle 32-step divider.
// A waiting result stalls only a later byte that itself produces a result.
// Reset clears stack count, push flag and output valid; stack words need no clear.
`timescale 1ns / 1ps
module stack_bytecode_executor_top import sbe_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	sbe_code_if.sink   code,
	sbe_result_if.source result
);

	sbe_cmd_t cmd;
	sbe_sts_t sts;
	logic     ctrl_ready;
	logic     res_valid;
	value_t   res_value;
	status_t  res_status;

	sbe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code.valid),
		.code_ready (ctrl_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sbe_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.code_byte     (code.code_byte),
		.cmd           (cmd),
		.sts           (sts),
		.result_valid  (res_valid),
		.result_ready  (result.ready),
		.printed_value (res_value),
		.status        (res_status)
	);

	assign code.ready           = ctrl_ready;
	assign result.valid         = res_valid;
	assign result.printed_value = res_value;
	assign result.status        = res_status;

endmodule

// ===== hw/rtl/sbe_datapath.sv =====
// Stack memory, count, operand registers, ALU, serial divider and output register
`timescale 1ns / 1ps
`include "stack_bytecode_executor_top_macros.svh"
module sbe_datapath import sbe_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  byte_t    code_byte,
	input  sbe_cmd_t cmd,
	output sbe_sts_t sts,
	output logic     result_valid,
	input  logic     result_ready,
	output value_t   printed_value,
	output status_t  status
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	word_t              stack_mem [STACK_DEPTH];
	logic [CNT_W-1:0]   cnt_q;
	logic               expect_imm_q;
	byte_t              byte_q;
	word_t              rd_q;
	word_t              right_q;
	word_t              left_q;
	word_t              res_q;
	word_t              quo_q;
	word_t              rem_q;
	word_t              dvs_q;
	logic               out_valid_q;
	value_t             out_val_q;
	status_t            out_status_q;

	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   cnt_m2;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic               wr_en;
	word_t              wr_data;
	logic [32:0]        div_shift;
	logic [32:0]        div_trial;
	word_t              mul_lo;

	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign cnt_m2  = cnt_q - CNT_W'(2);
	assign rd_addr = cmd.rd_second ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
	assign wr_en   = cmd.push_imm | cmd.wb;
	assign wr_addr = cmd.push_imm ? cnt_q[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
	assign wr_data = cmd.push_imm ? {24'd0, byte_q} : res_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			expect_imm_q <= 1'b0;
		end else begin
			if (cmd.push_imm)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.wb || cmd.pop)
				cnt_q <= cnt_m1;
			if (cmd.imm_set)
				expect_imm_q <= 1'b1;
			else if (cmd.imm_clr)
				expect_imm_q <= 1'b0;
		end
	end

	// restoring divide on magnitudes, one quotient bit per step
	assign div_shift = {rem_q, quo_q[31]};
	assign div_trial = div_shift - {1'b0, dvs_q};
	assign mul_lo    = left_q * right_q;

	always_ff @(posedge clk) begin
		if (cmd.byte_ld)
			byte_q <= code_byte;
		if (cmd.ld_right)
			right_q <= rd_q;
		if (cmd.ld_left)
			left_q <= rd_q;
		if (cmd.res_from_rd) begin
			res_q <= rd_q;
		end else if (cmd.alu_exec) begin
			case (byte_q)
				OP_ADD:  res_q <= left_q + right_q;
				OP_SUB:  res_q <= left_q - right_q;
				OP_MUL:  res_q <= mul_lo;
				default: res_q <= res_q;
			endcase
		end else if (cmd.div_fin) begin
			if (byte_q == OP_DIV)
				res_q <= (left_q[31] ^ right_q[31]) ? (32'd0 - quo_q) : quo_q;
			else
				res_q <= left_q[31] ? (32'd0 - rem_q) : rem_q;
		end
		if (cmd.div_init) begin
			quo_q <= left_q[31] ? (32'd0 - left_q) : left_q;
			dvs_q <= right_q[31] ? (32'd0 - right_q) : right_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!div_trial[32]) begin
				rem_q <= div_trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= div_shift[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.emit_ld) begin
			out_val_q    <= cmd.emit_zero ? value_t'(0) : value_t'(res_q);
			out_status_q <= cmd.emit_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_ld)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	assign result_valid  = out_valid_q;
	assign printed_value = out_val_q;
	assign status        = out_status_q;

	always_comb begin
		sts.code       = byte_q;
		sts.expect_imm = expect_imm_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.cnt_lt2    = (cnt_q < CNT_W'(2));
		sts.cnt_full   = (cnt_q == CNT_W'(STACK_DEPTH));
		sts.right_zero = (right_q == '0);
		sts.out_free   = !out_valid_q || result_ready;
	end

	`SBE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH), "stack count past depth")
	`SBE_ASSERT_SAME(a_push_room, cmd.push_imm, cnt_q < CNT_W'(STACK_DEPTH), "push on full stack")
	`SBE_ASSERT_SAME(a_wb_operands, cmd.wb, cnt_q >= CNT_W'(2), "write-back without two operands")

endmodule

// ===== hw/rtl/sbe_ctrl.sv =====
// Controller state machine: decodes bytecode and sequences the datapath
`timescale 1ns / 1ps
`include "stack_bytecode_executor_top_macros.svh"
module sbe_ctrl import sbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     code_valid,
	output logic     code_ready,
	input  sbe_sts_t sts,
	output sbe_cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_PRINT_RD = 4'd2;
	localparam logic [3:0] S_RD_R     = 4'd3;
	localparam logic [3:0] S_RD_L     = 4'd4;
	localparam logic [3:0] S_EXEC     = 4'd5;
	localparam logic [3:0] S_DIV      = 4'd6;
	localparam logic [3:0] S_DIVFIN   = 4'd7;
	localparam logic [3:0] S_WB       = 4'd8;
	localparam logic [3:0] S_EMIT     = 4'd9;

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_d;
	status_t              emit_status_q;
	status_t              emit_status_d;
	logic                 emit_zero_q;
	logic                 emit_zero_d;
	logic                 accept;
	logic                 is_arith;
	logic                 is_divmod;

	assign code_ready = (state_q == S_IDLE);
	assign accept     = code_valid && code_ready;
	assign is_arith   = (sts.code <= OP_MOD);
	assign is_divmod  = (sts.code == OP_DIV) || (sts.code == OP_MOD);

	always_comb begin
		state_d       = state_q;
		div_cnt_d     = div_cnt_q;
		emit_status_d = emit_status_q;
		emit_zero_d   = emit_zero_q;
		cmd           = '0;
		cmd.byte_ld   = accept;
		cmd.emit_zero   = emit_zero_q;
		cmd.emit_status = emit_status_q;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (sts.expect_imm) begin
					cmd.imm_clr = 1'b1;
					if (sts.cnt_full) begin
						emit_status_d = ST_OVER;
						emit_zero_d   = 1'b1;
						state_d       = S_EMIT;
					end else begin
						cmd.push_imm = 1'b1;
					end
				end else if (sts.code == OP_PUSH) begin
					cmd.imm_set = 1'b1;
				end else if (sts.code == OP_PRINT) begin
					if (sts.cnt_zero) begin
						emit_status_d = ST_UNDER;
						emit_zero_d   = 1'b1;
						state_d       = S_EMIT;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_PRINT_RD;
					end
				end else if (is_arith) begin
					if (sts.cnt_lt2) begin
						emit_status_d = ST_UNDER;
						emit_zero_d   = 1'b1;
						state_d       = S_EMIT;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_RD_R;
					end
				end
			end
			S_PRINT_RD: begin
				cmd.res_from_rd = 1'b1;
				cmd.pop         = 1'b1;
				emit_status_d   = ST_OK;
				emit_zero_d     = 1'b0;
				state_d         = S_EMIT;
			end
			S_RD_R: begin
				cmd.ld_right  = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_second = 1'b1;
				state_d       = S_RD_L;
			end
			S_RD_L: begin
				cmd.ld_left = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				if (is_divmod && sts.right_zero) begin
					emit_status_d = ST_DIVZERO;
					emit_zero_d   = 1'b1;
					state_d       = S_EMIT;
				end else if (is_divmod) begin
					cmd.div_init = 1'b1;
					div_cnt_d    = '0;
					state_d      = S_DIV;
				end else begin
					cmd.alu_exec = 1'b1;
					state_d      = S_WB;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = S_DIVFIN;
			end
			S_DIVFIN: begin
				cmd.div_fin = 1'b1;
				state_d     = S_WB;
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_IDLE;
			end
			S_EMIT: begin
				// wait here while the previous result is still held
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			div_cnt_q     <= '0;
			emit_status_q <= ST_OK;
			emit_zero_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			div_cnt_q     <= div_cnt_d;
			emit_status_q <= emit_status_d;
			emit_zero_q   <= emit_zero_d;
		end
	end

	`SBE_ASSERT_SAME(a_emit_free, cmd.emit_ld, sts.out_free, "result overwritten before taken")
	`SBE_ASSERT_NEXT(a_accept_decode, accept, state_q == S_DECODE, "accepted byte not decoded")
	`SBE_ASSERT_NEXT(a_divzero_emit, (state_q == S_EXEC) && is_divmod && sts.right_zero, (state_q == S_EMIT) && (emit_status_q == ST_DIVZERO), "zero divisor not reported")

endmodule

// ===== verif/stack_bytecode_executor_top_tb.sv =====
// Self-checking testbench for the stack bytecode executor top level
`timescale 1ns / 1ps
module stack_bytecode_executor_top_tb import sbe_pkg::*; ();

	localparam int CLK_PERIOD   = 12;
	localparam int STACK_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 1300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 800000;

	typedef struct {
		word_t   printed_value;
		status_t status;
	} print_result_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	sbe_code_if   code_ch ();
	sbe_result_if result_ch ();

	stack_bytecode_executor_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.result (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the machine state, updated on every accepted byte
	word_t       model_stack [STACK_DEPTH];
	int unsigned model_count = 0;
	bit          model_imm_pending = 1'b0;

	print_result_t expected_prints [$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   burst_left = 0;
	int unsigned   result_hold_left = 0;

	function automatic void expect_print(input word_t v, input status_t s);
		print_result_t r;
		r.printed_value = v;
		r.status = s;
		expected_prints.insert(expected_prints.size(), r);
	endfunction

	function automatic void predict_code(input byte_t b);
		word_t lhs, rhs, res, mag_l, mag_r;
		if (model_imm_pending) begin
			model_imm_pending = 1'b0;
			if (model_count >= STACK_DEPTH) begin
				expect_print('0, ST_OVER);
			end else begin
				model_stack[model_count] = word_t'(b);
				model_count++;
			end
			return;
		end
		case (b)
			OP_PUSH: begin
				model_imm_pending = 1'b1;
			end
			OP_PRINT: begin
				if (model_count == 0) begin
					expect_print('0, ST_UNDER);
				end else begin
					model_count--;
					expect_print(model_stack[model_count], ST_OK);
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				if (model_count < 2) begin
					expect_print('0, ST_UNDER);
				end else begin
					rhs = model_stack[model_count - 1];
					lhs = model_stack[model_count - 2];
					if ((b == OP_DIV || b == OP_MOD) && rhs == '0) begin
						// operands stay put on divide by zero
						expect_print('0, ST_DIVZERO);
					end else begin
						mag_l = lhs[31] ? 32'd0 - lhs : lhs;
						mag_r = rhs[31] ? 32'd0 - rhs : rhs;
						case (b)
							OP_ADD: res = lhs + rhs;
							OP_SUB: res = lhs - rhs;
							OP_MUL: res = lhs * rhs;
							OP_DIV: begin
								res = mag_l / mag_r;
								if (lhs[31] != rhs[31])
									res = 32'd0 - res;
							end
							default: begin
								// remainder takes the sign of the dividend
								res = mag_l % mag_r;
								if (lhs[31])
									res = 32'd0 - res;
							end
						endcase
						model_count--;
						model_stack[model_count - 1] = res;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic byte_t rand_immediate();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
				$time, what, got, want);
	endtask

	// Called at a rising edge; returns at the edge where the byte is taken
	task automatic send_code(input byte_t b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				code_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		code_ch.valid     <= 1'b1;
		code_ch.code_byte <= b;
		@(posedge clk);
		while (!code_ch.ready)
			@(posedge clk);
		predict_code(b);
	endtask

	task automatic push_imm(input byte_t b);
		send_code(OP_PUSH);
		send_code(b);
	endtask

	task automatic empty_stack();
		if (model_imm_pending)
			send_code(rand_immediate());
		while (model_count > 0)
			send_code(OP_PRINT);
	endtask

	// 2^7 * 2^7 * 2^7 * 2^7 * 2^3 wraps to the most negative word
	task automatic build_most_negative();
		push_imm(8'd128);
		push_imm(8'd128);
		send_code(OP_MUL);
		repeat (2) begin
			push_imm(8'd128);
			send_code(OP_MUL);
		end
		push_imm(8'd8);
		send_code(OP_MUL);
	endtask

	task automatic build_minus_one();
		push_imm(8'd0);
		push_imm(8'd1);
		send_code(OP_SUB);
	endtask

	task automatic test_underflow();
		empty_stack();
		send_code(OP_PRINT);
		for (int op = OP_ADD; op <= OP_MOD; op++)
			send_code(byte_t'(op));
		push_imm(8'd9);
		for (int op = OP_ADD; op <= OP_MOD; op++)
			send_code(byte_t'(op));
		send_code(OP_PRINT);
	endtask

	task automatic test_ignored_bytes();
		send_code(8'd7);
		send_code(8'd255);
		send_code(8'd128);
		// immediates that look like opcodes are still data
		push_imm(OP_PUSH);
		push_imm(OP_PRINT);
		send_code(OP_PRINT);
		send_code(OP_PRINT);
	endtask

	task automatic test_arith_extremes();
		empty_stack();
		build_most_negative();
		build_minus_one();
		send_code(OP_DIV);
		send_code(OP_PRINT);
		build_most_negative();
		build_minus_one();
		send_code(OP_MOD);
		send_code(OP_PRINT);
		build_most_negative();
		push_imm(8'd1);
		send_code(OP_SUB);
		send_code(OP_PRINT);
		push_imm(8'd255);
		push_imm(8'd255);
		send_code(OP_MUL);
		build_minus_one();
		send_code(OP_ADD);
		send_code(OP_PRINT);
	endtask

	task automatic test_divide_by_zero();
		empty_stack();
		push_imm(8'd7);
		push_imm(8'd0);
		send_code(OP_DIV);
		send_code(OP_MOD);
		send_code(OP_PRINT);
		send_code(OP_PRINT);
		push_imm(8'd0);
		push_imm(8'd0);
		send_code(OP_MOD);
		send_code(OP_DIV);
		empty_stack();
	endtask

	task automatic test_overflow();
		empty_stack();
		repeat (STACK_DEPTH)
			push_imm(rand_immediate());
		push_imm(rand_immediate());
		send_code(OP_ADD);
		push_imm(rand_immediate());
		push_imm(rand_immediate());
		send_code(OP_PRINT);
		empty_stack();
	endtask

	// Sink holds off while prints keep coming, so the input side backs up
	task automatic test_result_backpressure();
		empty_stack();
		result_hold_left = 400;
		repeat (40) begin
			push_imm(rand_immediate());
			send_code(OP_PRINT);
		end
	endtask

	task automatic test_random_programs();
		int unsigned counted;
		int unsigned pick;
		int unsigned push_cut;
		int unsigned print_cut;
		bit          climb;
		bit          was_imm;
		byte_t       b;
		counted = 0;
		climb = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			// climbing phases drive the stack towards full
			if ($urandom_range(0, 149) == 0)
				climb = !climb;
			push_cut  = climb ? 70 : 35;
			print_cut = climb ? 78 : 55;
			was_imm = model_imm_pending;
			if (model_imm_pending) begin
				b = rand_immediate();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					b = byte_t'($urandom_range(OP_PRINT + 1, 255));
				else if ((model_count < 2 && pick < 60) || pick < push_cut)
					b = OP_PUSH;
				else if (pick < print_cut)
					b = OP_PRINT;
				else
					b = byte_t'($urandom_range(OP_ADD, OP_MOD));
			end
			send_code(b);
			if (was_imm || b <= OP_PRINT)
				counted++;
		end
	endtask

	initial begin : result_sink
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned tick;
		mode = RX_ALWAYS;
		mode_left = 0;
		tick = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (result_hold_left > 0) begin
				result_ch.ready <= 1'b0;
				result_hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 90);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS:   result_ch.ready <= 1'b1;
					RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 4) == 0);
					RX_PERIODIC: result_ch.ready <= ((tick % 6) < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_prints
		print_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_prints.size() == 0) begin
				report_mismatch("transaction with nothing pending",
					result_ch.printed_value, '0);
			end else begin
				want = expected_prints.pop_front();
				if (result_ch.printed_value !== want.printed_value)
					report_mismatch("printed_value", result_ch.printed_value,
						want.printed_value);
				if (result_ch.status !== want.status)
					report_mismatch("status", 32'(result_ch.status), 32'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		code_ch.valid     <= 1'b0;
		code_ch.code_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_underflow();
		test_ignored_bytes();
		test_arith_extremes();
		test_divide_by_zero();
		test_overflow();
		test_result_backpressure();
		test_random_programs();
		code_ch.valid <= 1'b0;
		while (expected_prints.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
